// ===== rtl/calendar_period_progress_core_macros.svh =====
// ----------------------------------------------------------------------------
// calendar_period_progress_core_macros
// Assertion shorthands shared by the calendar period progress RTL.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_PERIOD_PROGRESS_CORE_MACROS_SVH
`define CALENDAR_PERIOD_PROGRESS_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define CPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define CPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// Types, widths, constants and lookup functions for calendar period progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpp_pkg;

    // input field widths
    localparam int MS_W    = 10;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int WDAY_W  = 3;
    localparam int MDAY_W  = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int YDAY_W  = 9;

    // internal widths
    localparam int DAYS_W    = 9;   // up to 511 days
    localparam int TOD_W     = 17;  // seconds within the day, out-of-range fields included
    localparam int DSEC_W    = 26;  // seconds from period start
    localparam int ELAPSED_W = 36;  // milliseconds, also holds twice any period
    localparam int MDAYS_W   = 5;
    localparam int Q25_W     = 10;
    localparam int YPROD_W   = 27;
    localparam int PROG_W    = 17;
    localparam int FRAC_W    = 16;
    localparam int STEP_W    = 6;
    localparam int SUBDIV_W  = 6;
    localparam int PROD_W    = PROG_W + SUBDIV_W;

    // one quotient bit per divider stage
    localparam int DIV_STAGES = PROG_W;

    localparam logic [MON_W-1:0]     MONTH_FEB    = 4'd1;
    localparam logic [YPROD_W-1:0]   Q25_RECIP    = 27'd5243;  // ~2^17/25
    localparam logic [YEAR_W-1:0]    YEAR_DIV25   = 14'd25;
    localparam logic [TOD_W-1:0]     SEC_PER_MIN  = 17'd60;
    localparam logic [TOD_W-1:0]     SEC_PER_HOUR = 17'd3600;
    localparam logic [DSEC_W-1:0]    SEC_PER_DAY  = 26'd86400;
    localparam logic [ELAPSED_W-1:0] MS_PER_SEC   = 36'd1000;
    localparam logic [ELAPSED_W-1:0] MS_PER_MIN   = 36'd60000;
    localparam logic [ELAPSED_W-1:0] MS_PER_HOUR  = 36'd3600000;
    localparam logic [ELAPSED_W-1:0] MS_PER_DAY   = 36'd86400000;
    localparam logic [ELAPSED_W-1:0] MS_PER_WEEK  = 36'd604800000;
    localparam logic [ELAPSED_W-1:0] MS_PER_SEASON = 36'd7776000000;
    localparam logic [ELAPSED_W-1:0] MS_PER_YEAR  = 36'd31536000000;

    localparam logic [PROG_W-1:0] PROG_MAX   = 17'h1FFFF;
    localparam logic [PROG_W-1:0] TRIG_LIMIT = 17'd656;    // p*100 < 65536
    localparam logic [PROG_W-1:0] PROG_HALF  = 17'd32768;
    localparam logic [STEP_W-1:0] STEP_MAX   = 6'd63;

    typedef enum logic [2:0] {
        MODE_SECOND = 3'd0,
        MODE_MINUTE = 3'd1,
        MODE_HOUR   = 3'd2,
        MODE_DAY    = 3'd3,
        MODE_WEEK   = 3'd4,
        MODE_MONTH  = 3'd5,
        MODE_SEASON = 3'd6,
        MODE_YEAR   = 3'd7
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [MS_W-1:0]     millisecond;
        logic [SEC_W-1:0]    second;
        logic [MIN_W-1:0]    minute;
        logic [HOUR_W-1:0]   hour;
        logic [WDAY_W-1:0]   weekday;
        logic [MDAY_W-1:0]   month_day;
        logic [MON_W-1:0]    month;
        logic [YEAR_W-1:0]   full_year;
        logic [YDAY_W-1:0]   year_day;
    } t_query;

    typedef struct packed {
        t_mode                mode;
        logic [ELAPSED_W-1:0] elapsed;
        logic [ELAPSED_W-1:0] period;
    } t_div_req;

    typedef struct packed {
        t_mode             mode;
        logic [PROG_W-1:0] progress;
    } t_div_res;

    // days in month, no leap day; months past December count 31
    function automatic logic [MDAYS_W-1:0] month_len(input logic [MON_W-1:0] m);
        logic [MDAYS_W-1:0] d;
        unique case (m)
            4'd1:                     d = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  d = 5'd30;
            default:                  d = 5'd31;
        endcase
        return d;
    endfunction

    // whole days from the quarter start to the start of month m
    function automatic logic [6:0] quarter_off(input logic [MON_W-1:0] m);
        logic [6:0] d;
        unique case (m)
            4'd1, 4'd7, 4'd10, 4'd13: d = 7'd31;
            4'd2:                     d = 7'd59;
            4'd4:                     d = 7'd30;
            4'd5, 4'd11:              d = 7'd61;
            4'd8, 4'd14:              d = 7'd62;
            default:                  d = 7'd0;
        endcase
        return d;
    endfunction

    function automatic logic [SUBDIV_W-1:0] subdiv(input t_mode md);
        logic [SUBDIV_W-1:0] s;
        unique case (md)
            MODE_SECOND: s = 6'd4;
            MODE_MINUTE: s = 6'd60;
            MODE_HOUR:   s = 6'd24;
            MODE_DAY:    s = 6'd7;
            MODE_WEEK:   s = 6'd4;
            MODE_MONTH:  s = 6'd12;
            MODE_SEASON: s = 6'd3;
            default:     s = 6'd12;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpp_front.sv =====
// ----------------------------------------------------------------------------
// cpp_front
// Three-stage front end: elapsed milliseconds and period length per mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire cpp_pkg::t_query   i_query,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output cpp_pkg::t_div_req      o_req
);

    logic w_en;

    // stage 1: day count, time of day, year/25 estimate
    logic                          r1_valid;
    cpp_pkg::t_mode                r1_mode;
    logic [cpp_pkg::MS_W-1:0]      r1_ms;
    logic [cpp_pkg::DAYS_W-1:0]    r1_days;
    logic [cpp_pkg::TOD_W-1:0]     r1_tod;
    logic [cpp_pkg::MON_W-1:0]     r1_mon;
    logic [cpp_pkg::YEAR_W-1:0]    r1_year;
    logic [cpp_pkg::Q25_W-1:0]     r1_q25;

    logic [cpp_pkg::MDAY_W-1:0]    n1_doff;
    logic [cpp_pkg::DAYS_W-1:0]    n1_days;
    logic [cpp_pkg::TOD_W-1:0]     n1_tod;
    logic [cpp_pkg::YPROD_W-1:0]   n1_yprod;

    // stage 2: seconds since period start, month length
    logic                          r2_valid;
    cpp_pkg::t_mode                r2_mode;
    logic [cpp_pkg::MS_W-1:0]      r2_ms;
    logic [cpp_pkg::DSEC_W-1:0]    r2_dsec;
    logic [cpp_pkg::MDAYS_W-1:0]   r2_mdays;

    logic [cpp_pkg::DSEC_W-1:0]    n2_dsec;
    logic [cpp_pkg::YEAR_W-1:0]    n2_r25;
    logic                          n2_leap;
    logic [cpp_pkg::MDAYS_W-1:0]   n2_mdays;

    // stage 3: milliseconds and period
    logic                          r3_valid;
    cpp_pkg::t_div_req             r3_req;
    cpp_pkg::t_div_req             n3_req;

    assign w_en    = !r3_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r3_valid;
    assign o_req   = r3_req;

    always_comb begin
        n1_doff  = (i_query.month_day == '0) ? '0 : i_query.month_day - 5'd1;
        n1_yprod = cpp_pkg::YPROD_W'(i_query.full_year) * cpp_pkg::Q25_RECIP;
        unique case (i_query.mode)
            cpp_pkg::MODE_WEEK:   n1_days = cpp_pkg::DAYS_W'(i_query.weekday);
            cpp_pkg::MODE_MONTH:  n1_days = cpp_pkg::DAYS_W'(n1_doff);
            cpp_pkg::MODE_SEASON: n1_days = cpp_pkg::DAYS_W'(n1_doff)
                                          + cpp_pkg::DAYS_W'(cpp_pkg::quarter_off(i_query.month));
            cpp_pkg::MODE_YEAR:   n1_days = i_query.year_day;
            default:              n1_days = '0;
        endcase
        unique case (i_query.mode)
            cpp_pkg::MODE_SECOND: n1_tod = '0;
            cpp_pkg::MODE_MINUTE: n1_tod = cpp_pkg::TOD_W'(i_query.second);
            cpp_pkg::MODE_HOUR:   n1_tod = cpp_pkg::TOD_W'(i_query.minute) * cpp_pkg::SEC_PER_MIN
                                         + cpp_pkg::TOD_W'(i_query.second);
            default:              n1_tod = cpp_pkg::TOD_W'(i_query.hour) * cpp_pkg::SEC_PER_HOUR
                                         + cpp_pkg::TOD_W'(i_query.minute) * cpp_pkg::SEC_PER_MIN
                                         + cpp_pkg::TOD_W'(i_query.second);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
        end
        if (w_en) begin
            r1_mode <= i_query.mode;
            r1_ms   <= i_query.millisecond;
            r1_days <= n1_days;
            r1_tod  <= n1_tod;
            r1_mon  <= i_query.month;
            r1_year <= i_query.full_year;
            r1_q25  <= n1_yprod[cpp_pkg::YPROD_W-1:cpp_pkg::YPROD_W-cpp_pkg::Q25_W];
        end
    end

    // leap: y%4==0 and (y%25!=0 or y%16==0)
    always_comb begin
        n2_dsec  = cpp_pkg::DSEC_W'(r1_days) * cpp_pkg::SEC_PER_DAY
                 + cpp_pkg::DSEC_W'(r1_tod);
        n2_r25   = r1_year - cpp_pkg::YEAR_W'(cpp_pkg::YEAR_W'(r1_q25) * cpp_pkg::YEAR_DIV25);
        n2_leap  = (r1_year[1:0] == 2'b00) && ((n2_r25 != '0) || (r1_year[3:0] == 4'b0000));
        n2_mdays = cpp_pkg::month_len(r1_mon)
                 + cpp_pkg::MDAYS_W'((r1_mon == cpp_pkg::MONTH_FEB) && n2_leap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
        if (w_en) begin
            r2_mode  <= r1_mode;
            r2_ms    <= r1_ms;
            r2_dsec  <= n2_dsec;
            r2_mdays <= n2_mdays;
        end
    end

    always_comb begin
        n3_req.mode = r2_mode;
        if (r2_mode == cpp_pkg::MODE_SECOND) begin
            n3_req.elapsed = cpp_pkg::ELAPSED_W'(r2_ms);
        end else begin
            n3_req.elapsed = cpp_pkg::ELAPSED_W'(r2_dsec) * cpp_pkg::MS_PER_SEC
                           + cpp_pkg::ELAPSED_W'(r2_ms);
        end
        unique case (r2_mode)
            cpp_pkg::MODE_SECOND: n3_req.period = cpp_pkg::MS_PER_SEC;
            cpp_pkg::MODE_MINUTE: n3_req.period = cpp_pkg::MS_PER_MIN;
            cpp_pkg::MODE_HOUR:   n3_req.period = cpp_pkg::MS_PER_HOUR;
            cpp_pkg::MODE_DAY:    n3_req.period = cpp_pkg::MS_PER_DAY;
            cpp_pkg::MODE_WEEK:   n3_req.period = cpp_pkg::MS_PER_WEEK;
            cpp_pkg::MODE_MONTH:  n3_req.period = cpp_pkg::ELAPSED_W'(r2_mdays)
                                                * cpp_pkg::MS_PER_DAY;
            cpp_pkg::MODE_SEASON: n3_req.period = cpp_pkg::MS_PER_SEASON;
            default:              n3_req.period = cpp_pkg::MS_PER_YEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
        if (w_en) begin
            r3_req <= n3_req;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cpp_div.sv =====
// ----------------------------------------------------------------------------
// cpp_div
// Pipelined restoring divider: floor(elapsed * 2^16 / period), saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_period_progress_core_macros.svh"

module cpp_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire cpp_pkg::t_div_req   i_req,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output cpp_pkg::t_div_res        o_res
);

    localparam int NS   = cpp_pkg::DIV_STAGES;
    localparam int LAST = NS - 1;
    localparam int EW   = cpp_pkg::ELAPSED_W;

    logic                        w_en;

    logic [NS-1:0]               r_v;
    logic                        r_sat  [NS];
    logic [EW-1:0]               r_rem  [NS];
    logic [EW-1:0]               r_len  [NS];
    logic [cpp_pkg::PROG_W-1:0]  r_q    [NS];
    cpp_pkg::t_mode              r_mode [NS];

    logic [EW-1:0]               n_rem  [NS];
    logic                        n_bit  [NS];
    logic                        n_sat;

    assign w_en    = !r_v[LAST] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v[LAST];
    assign o_res.mode     = r_mode[LAST];
    assign o_res.progress = r_sat[LAST] ? cpp_pkg::PROG_MAX : r_q[LAST];

    // first stage: saturation when elapsed >= 2*period, then the 2^16 bit
    always_comb begin
        n_sat    = {1'b0, i_req.elapsed} >= {i_req.period, 1'b0};
        n_bit[0] = i_req.elapsed >= i_req.period;
        n_rem[0] = n_bit[0] ? i_req.elapsed - i_req.period : i_req.elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_valid;
        end
        if (w_en) begin
            r_sat[0]  <= n_sat;
            r_rem[0]  <= n_rem[0];
            r_len[0]  <= i_req.period;
            r_q[0]    <= cpp_pkg::PROG_W'(n_bit[0]);
            r_mode[0] <= i_req.mode;
        end
    end

    // remaining stages: one quotient bit each, remainder stays below period
    for (genvar k = 1; k < NS; k++) begin : g_stage
        logic [EW-1:0] w_sh;

        assign w_sh     = {r_rem[k-1][EW-2:0], 1'b0};
        assign n_bit[k] = w_sh >= r_len[k-1];
        assign n_rem[k] = n_bit[k] ? w_sh - r_len[k-1] : w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (w_en) begin
                r_sat[k]  <= r_sat[k-1];
                r_rem[k]  <= n_rem[k];
                r_len[k]  <= r_len[k-1];
                r_q[k]    <= {r_q[k-1][cpp_pkg::PROG_W-2:0], n_bit[k]};
                r_mode[k] <= r_mode[k-1];
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_chk
        `CPP_ASSERT_IMP(a_rem_below_len, i_clk, i_rst_n, r_v[k] && !r_sat[k], r_rem[k] < r_len[k], "divider remainder not below period")
    end

    `CPP_ASSERT_IMP(a_len_nonzero, i_clk, i_rst_n, r_v[0], r_len[0] != '0, "zero period entered divider")
    `CPP_ASSERT_NXT(a_tail_holds, i_clk, i_rst_n, r_v[LAST] && !i_ready, r_v[LAST] && $stable(r_q[LAST]) && $stable(r_sat[LAST]), "stalled divider result changed")

endmodule

`default_nettype wire

// ===== rtl/cpp_post.sv =====
// ----------------------------------------------------------------------------
// cpp_post
// Output stage: step index, trigger and half gates, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpp_post (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire cpp_pkg::t_div_res             i_res,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [cpp_pkg::PROG_W-1:0]         o_progress,
    output logic [cpp_pkg::STEP_W-1:0]         o_step_index,
    output logic                               o_trigger,
    output logic                               o_first_half,
    output logic                               o_second_half
);

    localparam int STW = cpp_pkg::PROD_W - cpp_pkg::FRAC_W;

    logic                             w_en;
    logic [cpp_pkg::PROD_W-1:0]       n_prod;
    logic [STW-1:0]                   n_st;
    logic [cpp_pkg::STEP_W-1:0]       n_step;

    logic                             r_valid;
    logic [cpp_pkg::PROG_W-1:0]       r_progress;
    logic [cpp_pkg::STEP_W-1:0]       r_step;
    logic                             r_trigger;
    logic                             r_first;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        n_prod = cpp_pkg::PROD_W'(i_res.progress)
               * cpp_pkg::PROD_W'(cpp_pkg::subdiv(i_res.mode));
        n_st   = n_prod[cpp_pkg::PROD_W-1:cpp_pkg::FRAC_W];
        n_step = (n_st > STW'(cpp_pkg::STEP_MAX)) ? cpp_pkg::STEP_MAX
                                                   : n_st[cpp_pkg::STEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
        if (w_en) begin
            r_progress <= i_res.progress;
            r_step     <= n_step;
            r_trigger  <= i_res.progress < cpp_pkg::TRIG_LIMIT;
            r_first    <= i_res.progress < cpp_pkg::PROG_HALF;
        end
    end

    assign o_valid       = r_valid;
    assign o_progress    = r_progress;
    assign o_step_index  = r_step;
    assign o_trigger     = r_trigger;
    assign o_first_half  = r_first;
    assign o_second_half = !r_first;

endmodule

`default_nettype wire

// ===== rtl/calendar_period_progress_core.sv =====
// Pipeline: 3 front stages, 17 divider stages and 1 output register lie
//   between an accepted input request and o_m_tvalid.
// Throughput: one request per cycle while not stalled; the 17-stage restoring
//   divider, one quotient bit per stage, moves one request per clock unless stalled.
// Reset: i_rst_n synchronous active low, clears all valid bits; no other state.
// ----------------------------------------------------------------------------
// calendar_period_progress_core
// Elapsed fraction of a calendar period from a broken-down timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_period_progress_core_macros.svh"

module calendar_period_progress_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // millisecond[9:0] second[15:10] minute[21:16] hour[26:22] weekday[29:27]
    // month_day[34:30] month[38:35] full_year[52:39] year_day[61:53], 0 pad
    input  wire logic [63:0] i_s_tdata,
    // mode[2:0]
    input  wire logic [2:0]  i_s_tuser,
    // result side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // progress[16:0] step_index[22:17] trigger[23] first_half[24]
    // second_half[25], 0 pad
    output logic [31:0]      o_m_tdata
);

    cpp_pkg::t_query                w_query;
    cpp_pkg::t_div_req              w_req;
    cpp_pkg::t_div_res              w_res;
    logic                           w_req_valid;
    logic                           w_req_ready;
    logic                           w_res_valid;
    logic                           w_res_ready;

    logic [cpp_pkg::PROG_W-1:0]     w_progress;
    logic [cpp_pkg::STEP_W-1:0]     w_step;
    logic                           w_trigger;
    logic                           w_first_half;
    logic                           w_second_half;

    // Unpack the request. Mode selects the period and rides in tuser.
    assign w_query.mode        = cpp_pkg::t_mode'(i_s_tuser);
    assign w_query.millisecond = i_s_tdata[9:0];
    assign w_query.second      = i_s_tdata[15:10];
    assign w_query.minute      = i_s_tdata[21:16];
    assign w_query.hour        = i_s_tdata[26:22];
    assign w_query.weekday     = i_s_tdata[29:27];
    assign w_query.month_day   = i_s_tdata[34:30];
    assign w_query.month       = i_s_tdata[38:35];
    assign w_query.full_year   = i_s_tdata[52:39];
    assign w_query.year_day    = i_s_tdata[61:53];

    // Front end: day count and time of day, then seconds and month length
    // (leap rule on the full year), then milliseconds and period length.
    cpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_query (w_query),
        .o_valid (w_req_valid),
        .i_ready (w_req_ready),
        .o_req   (w_req)
    );

    // Divider: saturates at 2.0 (elapsed >= twice the period), otherwise
    // produces 17 quotient bits of elapsed * 2^16 / period.
    cpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_req_valid),
        .o_ready (w_req_ready),
        .i_req   (w_req),
        .o_valid (w_res_valid),
        .i_ready (w_res_ready),
        .o_res   (w_res)
    );

    // Output register. Each segment stalls as a whole only when its last
    // stage holds a result the next segment cannot take, so bubbles fill in.
    cpp_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_res_valid),
        .o_ready       (w_res_ready),
        .i_res         (w_res),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_progress    (w_progress),
        .o_step_index  (w_step),
        .o_trigger     (w_trigger),
        .o_first_half  (w_first_half),
        .o_second_half (w_second_half)
    );

    assign o_m_tdata = {6'b0, w_second_half, w_first_half, w_trigger, w_step, w_progress};

    `CPP_ASSERT_IMP(a_halves_split, i_clk, i_rst_n, o_m_tvalid, w_first_half != w_second_half, "half gates not complementary")
    `CPP_ASSERT_IMP(a_trigger_first, i_clk, i_rst_n, o_m_tvalid && w_trigger, w_first_half && (w_step == '0), "trigger outside first step")
    `CPP_ASSERT_IMP(a_sat_step, i_clk, i_rst_n, o_m_tvalid && (w_progress == cpp_pkg::PROG_MAX), w_second_half && !w_trigger, "saturated progress with wrong gates")

endmodule

`default_nettype wire

// ===== tb/sv/tb_calendar_period_progress_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_period_progress_core
// Self-checking bench: timestamps go in on the request stream, and each
// progress result is compared field by field with an in-bench prediction.
// Directed corner cases come first, then random traffic with random
// stalls on both sides, and a final back-to-back stretch.
// ----------------------------------------------------------------------------

module tb_calendar_period_progress_core;

    import cpp_pkg::*;

    // subdivision count per mode and month lengths (no leap day); the
    // months past December are all 31 days long
    localparam int unsigned SUBDIVISIONS [8]    = '{4, 60, 24, 7, 4, 12, 3, 12};
    localparam int unsigned DAYS_PER_MONTH [16] = '{31, 28, 31, 30, 31, 30, 31, 31,
                                                    30, 31, 30, 31, 31, 31, 31, 31};
    localparam longint unsigned PROGRESS_CEIL   = 131071;
    localparam longint unsigned STEP_CEIL       = 63;
    localparam longint unsigned SECONDS_PER_DAY = 86400;

    typedef struct packed {
        logic [16:0] progress;
        logic [5:0]  step_index;
        logic        trigger;
        logic        first_half;
        logic        second_half;
    } t_progress_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // millisecond second minute hour weekday month_day month full_year
    // year_day, 0 pad
    logic [63:0] i_s_tdata  = '0;
    // mode
    logic [2:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b1;
    // progress step_index trigger first_half second_half, 0 pad
    logic [31:0] o_m_tdata;

    t_progress_result pending_progress [$];
    int unsigned      mismatch_count = 0;
    bit               idling_on      = 1'b1;
    int unsigned      ready_stall    = 0;

    calendar_period_progress_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop in case the pipeline hangs
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic longint unsigned days_in_month(input logic [3:0] mon,
                                                      input logic [13:0] yr);
        longint unsigned d;
        d = DAYS_PER_MONTH[mon];
        // Gregorian leap day, February only
        if (mon == 4'd1 && (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0)))
            d++;
        return d;
    endfunction

    function automatic t_progress_result predict_progress(input t_query q);
        t_progress_result r;
        longint unsigned  day_off, days, tod, elapsed, period, p, st;
        int               m;
        day_off = (q.month_day == 0) ? 0 : q.month_day - 1;
        days    = 0;
        tod     = longint'(q.hour) * 3600 + longint'(q.minute) * 60 + q.second;
        case (q.mode)
            MODE_SECOND: period = 1;
            MODE_MINUTE: begin
                tod    = q.second;
                period = 60;
            end
            MODE_HOUR: begin
                tod    = longint'(q.minute) * 60 + q.second;
                period = 3600;
            end
            MODE_DAY:   period = SECONDS_PER_DAY;
            MODE_WEEK: begin
                days   = q.weekday;
                period = 7 * SECONDS_PER_DAY;
            end
            MODE_MONTH: begin
                days   = day_off;
                period = days_in_month(q.month, q.full_year) * SECONDS_PER_DAY;
            end
            MODE_SEASON: begin
                // whole months since the quarter start, never leap-adjusted
                days = day_off;
                for (m = (q.month / 3) * 3; m < q.month; m++)
                    days += DAYS_PER_MONTH[m];
                period = 90 * SECONDS_PER_DAY;
            end
            default: begin
                days   = q.year_day;
                period = 365 * SECONDS_PER_DAY;
            end
        endcase
        if (q.mode == MODE_SECOND)
            elapsed = q.millisecond;
        else
            elapsed = (days * SECONDS_PER_DAY + tod) * 1000 + q.millisecond;
        period = period * 1000;

        p = (elapsed << 16) / period;
        if (p > PROGRESS_CEIL)
            p = PROGRESS_CEIL;
        st = (p * SUBDIVISIONS[q.mode]) >> 16;
        if (st > STEP_CEIL)
            st = STEP_CEIL;

        r.progress    = p[16:0];
        r.step_index  = st[5:0];
        r.trigger     = (p * 100 < 65536);
        r.first_half  = (p < 32768);
        r.second_half = (p >= 32768);
        return r;
    endfunction

    // ------------------------------------------------------------- checking

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_progress_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_progress.size() == 0) begin
                $display("%0t: result expected none actual %h", $time, o_m_tdata);
                mismatch_count++;
            end else begin
                want = pending_progress.pop_front();
                check_field("progress",    want.progress,    o_m_tdata[16:0]);
                check_field("step_index",  want.step_index,  o_m_tdata[22:17]);
                check_field("trigger",     want.trigger,     o_m_tdata[23]);
                check_field("first_half",  want.first_half,  o_m_tdata[24]);
                check_field("second_half", want.second_half, o_m_tdata[25]);
                check_field("pad",         0,                o_m_tdata[31:26]);
            end
        end
    end

    // result-side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (ready_stall > 0)
            ready_stall--;
        else if (idling_on && $urandom_range(0, 7) == 0)
            ready_stall = $urandom_range(1, 10);
        i_m_tready <= (ready_stall == 0);
    end

    // ------------------------------------------------------------- stimulus

    function automatic t_query make_query(input t_mode md, input int ms, input int sec,
                                          input int mn, input int hr, input int wd,
                                          input int mday, input int mon, input int yr,
                                          input int yday);
        t_query q;
        q.mode        = md;
        q.millisecond = ms;
        q.second      = sec;
        q.minute      = mn;
        q.hour        = hr;
        q.weekday     = wd;
        q.month_day   = mday;
        q.month       = mon;
        q.full_year   = yr;
        q.year_day    = yday;
        return q;
    endfunction

    // one request; valid stays high into the next call unless a gap is drawn
    task automatic send_query(input t_query q);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= q.mode;
        i_s_tdata  <= {2'b00, q.year_day, q.full_year, q.month, q.month_day,
                       q.weekday, q.hour, q.minute, q.second, q.millisecond};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pending_progress.push_back(predict_progress(q));
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    function automatic t_query random_query(input bit noise);
        t_query q;
        if (noise) begin
            // raw bits: out-of-range fields, day zero, months past December
            q = t_query'({$urandom, $urandom, $urandom});
        end else begin
            q.mode        = t_mode'($urandom_range(0, 7));
            q.millisecond = $urandom_range(0, 999);
            q.second      = $urandom_range(0, 60);
            q.minute      = $urandom_range(0, 59);
            q.hour        = $urandom_range(0, 23);
            q.weekday     = $urandom_range(0, 6);
            q.month       = $urandom_range(0, 11);
            q.full_year   = $urandom_range(0, 9999);
            q.month_day   = $urandom_range(1, days_in_month(q.month, q.full_year));
            q.year_day    = $urandom_range(0, 365);
        end
        return q;
    endfunction

    task automatic test_each_mode();
        t_mode md;
        for (int i = 0; i < 8; i++) begin
            md = t_mode'(i);
            send_query(make_query(md, 500, 30, 30, 12, 3, 15, 6, 2021, 180));
        end
    endtask

    task automatic test_field_extremes();
        send_query(make_query(MODE_SECOND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // every field at its top bit pattern: progress passes 1.0 without saturating
        send_query(make_query(MODE_YEAR, 1023, 63, 63, 31, 7, 31, 15, 16383, 511));
        send_query(make_query(MODE_DAY, 999, 59, 59, 23, 6, 31, 11, 9999, 365));
        // leap second ends the minute at exactly 1.0
        send_query(make_query(MODE_MINUTE, 0, 60, 0, 0, 0, 1, 0, 2016, 0));
        send_query(make_query(MODE_WEEK, 999, 60, 59, 23, 6, 1, 0, 0, 0));
    endtask

    task automatic test_leap_february();
        send_query(make_query(MODE_MONTH, 0, 0, 0, 12, 0, 29, 1, 2000, 59));
        send_query(make_query(MODE_MONTH, 0, 0, 0, 12, 0, 29, 1, 1900, 59));
        send_query(make_query(MODE_MONTH, 0, 0, 0, 12, 0, 29, 1, 2024, 59));
        send_query(make_query(MODE_MONTH, 0, 0, 0, 12, 0, 29, 1, 2023, 59));
    endtask

    task automatic test_day_zero();
        send_query(make_query(MODE_MONTH, 5, 0, 0, 0, 0, 0, 3, 2020, 0));
        send_query(make_query(MODE_SEASON, 5, 0, 0, 0, 0, 0, 2, 2020, 0));
    endtask

    task automatic test_months_past_december();
        send_query(make_query(MODE_MONTH, 0, 0, 0, 0, 0, 31, 12, 2024, 0));
        send_query(make_query(MODE_MONTH, 0, 0, 0, 0, 0, 31, 15, 2024, 0));
        send_query(make_query(MODE_SEASON, 0, 0, 0, 0, 0, 31, 14, 2024, 0));
        send_query(make_query(MODE_SEASON, 0, 0, 0, 0, 0, 31, 15, 2024, 0));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_query(random_query($urandom_range(0, 5) == 0));
    endtask

    task automatic test_back_to_back(input int unsigned count);
        idling_on = 1'b0;
        for (int unsigned i = 0; i < count; i++)
            send_query(random_query($urandom_range(0, 5) == 0));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_each_mode();
        test_field_extremes();
        test_leap_february();
        test_day_zero();
        test_months_past_december();
        test_random_traffic(630);
        test_back_to_back(100);

        i_s_tvalid <= 1'b0;
        while (pending_progress.size() != 0)
            @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (30) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
